@@ hw/rtl/utf8_dfa_decoder_defines.svh @@
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_DFA_DECODER_DEFINES_SVH
`define UTF8_DFA_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U8DFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define U8DFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/u8dfa_pkg.sv @@
// Types, codes and tables of the UTF-8 DFA decoder.
package u8dfa_pkg;

   localparam int CP_WIDTH    = 21;
   localparam int STATE_WIDTH = 4;
   localparam int CLASS_WIDTH = 4;
   localparam int ROW_LEN     = 16;
   localparam int STATE_COUNT = 9;

   // DFA state codes.
   localparam logic [STATE_WIDTH-1:0] ST_ACCEPT = 4'd0;
   localparam logic [STATE_WIDTH-1:0] ST_REJECT = 4'd1;

   // Result kinds.
   localparam logic [1:0] KIND_COMPLETE  = 2'd0;
   localparam logic [1:0] KIND_INVALID   = 2'd1;
   localparam logic [1:0] KIND_TRUNCATED = 2'd2;

   localparam logic [5:0] PAYLOAD_MASK = 6'h3f;
   localparam logic [7:0] LEAD_MASK    = 8'hff;

   // Transition table, one row of sixteen classes per state.
   localparam logic [STATE_WIDTH-1:0] NEXT_STATE [STATE_COUNT*ROW_LEN] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
   };

   // Outcome of one decoding step.
   typedef struct packed {
      logic                   emit;
      logic [CP_WIDTH-1:0]    code_point;
      logic [1:0]             kind;
      logic                   end_of_string;
      logic [STATE_WIDTH-1:0] state_next;
      logic [CP_WIDTH-1:0]    partial_next;
   } u8dfa_step_type;

   // Character class of a byte, by ranges of the byte value.
   function automatic logic [CLASS_WIDTH-1:0] byte_class(input logic [7:0] b);
      logic [CLASS_WIDTH-1:0] cls;
      priority if (b < 8'h80) cls = 4'd0;
      else if (b < 8'h90) cls = 4'd1;
      else if (b < 8'ha0) cls = 4'd9;
      else if (b < 8'hc2) cls = (b < 8'hc0) ? 4'd7 : 4'd8;
      else if (b < 8'he0) cls = 4'd2;
      else if (b == 8'he0) cls = 4'd10;
      else if (b == 8'hed) cls = 4'd4;
      else if (b < 8'hf0) cls = 4'd3;
      else if (b == 8'hf0) cls = 4'd11;
      else if (b < 8'hf4) cls = 4'd6;
      else if (b == 8'hf4) cls = 4'd5;
      else cls = 4'd8;
      return cls;
   endfunction

endpackage

@@ hw/rtl/u8dfa_step.sv @@
// Combinational next-state and result logic for one byte of the decoder.
module u8dfa_step import u8dfa_pkg::*; (
   input  logic [STATE_WIDTH-1:0] state,
   input  logic [CP_WIDTH-1:0]    partial,
   input  logic [7:0]             byte_in,
   input  logic                   last_byte,
   output u8dfa_step_type         step
);

   logic [STATE_WIDTH-1:0] prev;
   logic [CLASS_WIDTH-1:0] cls;
   logic [7:0]             lead_bits;
   logic [CP_WIDTH-1:0]    partial_calc;
   logic [STATE_WIDTH-1:0] table_next;

   // Unused state codes behave as reject.
   assign prev = (state >= STATE_WIDTH'(STATE_COUNT)) ? ST_REJECT : state;
   assign cls  = byte_class(byte_in);

   // A lead byte keeps its payload bits; a continuation byte shifts six in.
   assign lead_bits    = (LEAD_MASK >> cls) & byte_in;
   assign partial_calc = (prev == ST_ACCEPT) ? {{(CP_WIDTH-8){1'b0}}, lead_bits}
                                             : {partial[CP_WIDTH-7:0],
                                                byte_in[5:0] & PAYLOAD_MASK};
   assign table_next   = NEXT_STATE[{prev, cls}];

   // Select the result and the state that follows it.
   always_comb begin
      step = '0;
      if (prev == ST_REJECT) begin
         step.emit          = last_byte;
         step.kind          = KIND_INVALID;
         step.end_of_string = 1'b1;
         step.state_next    = last_byte ? ST_ACCEPT : ST_REJECT;
         step.partial_next  = last_byte ? '0 : partial;
      end else if (table_next == ST_ACCEPT) begin
         step.emit          = 1'b1;
         step.code_point    = partial_calc;
         step.kind          = KIND_COMPLETE;
         step.end_of_string = last_byte;
         step.state_next    = ST_ACCEPT;
      end else if (table_next == ST_REJECT) begin
         step.emit          = 1'b1;
         step.kind          = KIND_INVALID;
         step.end_of_string = last_byte;
         step.state_next    = last_byte ? ST_ACCEPT : ST_REJECT;
      end else if (last_byte) begin
         step.emit          = 1'b1;
         step.kind          = KIND_TRUNCATED;
         step.end_of_string = 1'b1;
         step.state_next    = ST_ACCEPT;
      end else begin
         step.state_next    = table_next;
         step.partial_next  = partial_calc;
      end
   end

endmodule

@@ hw/rtl/utf8_dfa_decoder.sv @@
// Top level of the byte-serial UTF-8 decoder.
//
// The request channel takes one byte of a UTF-8 string per transaction,
// with req_last_byte set on the final byte of each string. The response
// channel carries at most one result per byte: a complete code point, an
// invalid-sequence error, or a truncation report at the end of a string.
// The result of the last byte always carries rsp_end_of_string.
// A byte is decoded in the cycle it is accepted; its result appears in the
// output register on the next cycle, and the block sustains one byte per
// cycle while no result is stalled. That rate is set by the loop through
// the DFA state and partial code point registers, which one table lookup
// and a six-bit shift update for each accepted byte.
// Bytes that produce no result leave the output payload registers untouched.
// While a result is held and rsp_ready is low, req_ready is low and the
// request channel stalls; a result taken in a cycle frees room for the
// next byte in that same cycle.
// Reset returns the DFA to the accept state with an empty partial code
// point and clears the pending result.
`include "utf8_dfa_decoder_defines.svh"

module utf8_dfa_decoder import u8dfa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_in,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CP_WIDTH-1:0] rsp_code_point,
   output logic [1:0]          rsp_kind,
   output logic                rsp_end_of_string
);

   logic [STATE_WIDTH-1:0] dfa_state_ff, dfa_state_in;
   logic [CP_WIDTH-1:0]    partial_ff, partial_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CP_WIDTH-1:0]    rsp_code_point_ff;
   logic [1:0]             rsp_kind_ff;
   logic                   rsp_eos_ff;
   logic                   req_accept;
   u8dfa_step_type         step;

   // Room for a byte whenever the output register is empty or being drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   u8dfa_step u_step (
      .state     (dfa_state_ff),
      .partial   (partial_ff),
      .byte_in   (req_byte_in),
      .last_byte (req_last_byte),
      .step      (step)
   );

   // Decoder state advances only on an accepted transaction.
   assign dfa_state_in = req_accept ? step.state_next : dfa_state_ff;
   assign partial_in   = req_accept ? step.partial_next : partial_ff;
   assign rsp_valid_in = req_accept ? step.emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dfa_state_ff <= ST_ACCEPT;
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dfa_state_ff <= dfa_state_in;
         partial_ff   <= partial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads only when a byte produces a result.
   always_ff @(posedge clock) begin
      if (req_accept && step.emit) begin
         rsp_code_point_ff <= step.code_point;
         rsp_kind_ff       <= step.kind;
         rsp_eos_ff        <= step.end_of_string;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_point    = rsp_code_point_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_end_of_string = rsp_eos_ff;

   // A held result blocks the request side.
   `U8DFA_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request accepted while a result is stalled")
   // The last byte of a string always yields a flagged result.
   `U8DFA_ASSERT_NEXT(a_last_gives_eos, clock, reset, req_accept && req_last_byte, rsp_valid && rsp_end_of_string, "last byte gave no end-of-string result")
   // The decoder is back in the accept state after each string.
   `U8DFA_ASSERT_NEXT(a_last_resets_dfa, clock, reset, req_accept && req_last_byte, dfa_state_ff == ST_ACCEPT && partial_ff == '0, "decoder state not cleared at end of string")
   // Error and truncation results carry no code point.
   `U8DFA_ASSERT_IMPLY(a_error_cp_zero, clock, reset, rsp_valid && rsp_kind != KIND_COMPLETE, rsp_code_point == '0, "error result with non-zero code point")

endmodule
